// File: rtl/core/jdcd_pkg.sv
// Package for the day-number-to-date converter: constants, control structs and
// the small month-length and leap-year tables. It depends on nothing else.
`default_nettype none

package jdcd_pkg;

  localparam int DAY_BITS_DEF = 30;
  localparam int YEAR_W       = 22;
  localparam int REM_W        = 18;   // holds any remainder below 146097
  localparam int JQ_W         = 11;   // Julian four-year count, below 1575
  localparam int CYC_W        = 9;    // year position inside the 400-year cycle

  localparam int unsigned GREG_START = 2299161;
  localparam int unsigned GREG_YEAR0 = 2299239;   // day number of 1 January 1583
  localparam logic [REM_W-1:0] JUL_CYCLE  = REM_W'(1461);
  localparam logic [REM_W-1:0] GREG_CYCLE = REM_W'(146097);

  typedef struct packed {
    logic start;
    logic greg;
  } div_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  function automatic logic [4:0] month_len(input logic leap, input logic [3:0] idx);
    logic [4:0] len;
    case (idx)
      4'd1:    len = leap ? 5'd29 : 5'd28;
      4'd3,
      4'd5,
      4'd8,
      4'd10:   len = 5'd30;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

  // Gregorian leap rule on the year's place in its 400-year cycle.
  function automatic logic cyc_leap(input logic [CYC_W-1:0] cyc);
    return (cyc[1:0] == 2'b00) && (cyc != CYC_W'(100)) && (cyc != CYC_W'(200)) &&
           (cyc != CYC_W'(300));
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/julian_day_to_calendar_date_top.sv
// Day-number-to-calendar-date converter, top level: handshakes, sequencer and
// the year and month walks. Depends on jdcd_pkg and jdcd_sdiv.
// The input channel carries one day number per transaction (in_valid, in_stall,
// in_day_number); the result channel carries one date per transaction
// (out_valid, out_stall, out_day_of_month, out_month, out_year_number,
// out_before_christ), one result per input, in order.
// One item is converted at a time: in_stall is high from the accepting edge
// until the edge that loads the finished date, so the next day number is taken
// only after that, and a new item is never accepted while one is in progress.
// The paths through the sequencer:
//   Julian dates (below 2299161): one division, then
//     up to 4 year steps and 12 month steps on a narrow subtractor.
//   Last days of 1582: no division.
//   Gregorian dates: one division, then up to 400 year steps in the
//     400-year cycle and up to 12 month steps; the year walk
//     sets the worst case.
// A finished date waits in the output register while the next item runs; if
// the receiver still stalls it when the next date is done, the sequencer holds
// in its final state until the register is taken. Reset (rst_n low,
// synchronous) empties the output register and idles the sequencer.
`default_nettype none

module julian_day_to_calendar_date_top #(
  parameter int DAY_BITS = jdcd_pkg::DAY_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [DAY_BITS-1:0]            in_day_number,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic [4:0]                          out_day_of_month,
  output logic [3:0]                          out_month,
  output logic [jdcd_pkg::YEAR_W-1:0]         out_year_number,
  output logic                                out_before_christ
);

  localparam int YW = jdcd_pkg::YEAR_W;
  localparam int RW = jdcd_pkg::REM_W;
  localparam int CW = jdcd_pkg::CYC_W;
  localparam int KW = jdcd_pkg::JQ_W + 2;

  localparam logic [DAY_BITS-1:0] GREG_START_D = DAY_BITS'(jdcd_pkg::GREG_START);
  localparam logic [DAY_BITS-1:0] GREG_YEAR0_D = DAY_BITS'(jdcd_pkg::GREG_YEAR0);

  // Sequencer states.
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_PREP = 4'd1;
  localparam logic [3:0] S_DIV  = 4'd2;
  localparam logic [3:0] S_JYR  = 4'd3;
  localparam logic [3:0] S_JK   = 4'd4;
  localparam logic [3:0] S_GADD = 4'd5;
  localparam logic [3:0] S_GYR  = 4'd6;
  localparam logic [3:0] S_MON  = 4'd7;
  localparam logic [3:0] S_FIN  = 4'd8;

  logic [3:0]          state_r, state_nxt;
  logic [DAY_BITS-1:0] num_r, num_nxt;
  logic                julian_r, julian_nxt;
  logic [RW-1:0]       rem_r, rem_nxt;
  logic [1:0]          yoff_r, yoff_nxt;
  logic [CW-1:0]       cyc_r, cyc_nxt;
  logic                leap_r, leap_nxt;
  logic [3:0]          mon_r, mon_nxt;
  logic [YW-1:0]       year_r, year_nxt;
  logic                bc_r, bc_nxt;
  logic [4:0]          dom_r, dom_nxt;
  logic [3:0]          month_r, month_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [4:0]          out_dom_r;
  logic [3:0]          out_mon_r;
  logic [YW-1:0]       out_year_r;
  logic                out_bc_r;

  jdcd_pkg::div_ctl_t  div_ctl;
  jdcd_pkg::div_stat_t div_stat;
  logic [DAY_BITS-1:0] div_dividend;
  logic [DAY_BITS-1:0] div_quo;
  logic [RW-1:0]       div_rem;

  logic                in_accept;
  logic                out_free;
  logic [6:0]          e_low;
  logic [8:0]          jyr_len;
  logic [8:0]          gyr_len;
  logic                gyr_leap;
  logic [4:0]          mon_len;
  logic [KW-1:0]       k_years;

  assign in_accept = in_valid && !in_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign out_free  = !out_valid_r || !out_stall;

  assign e_low    = 7'(num_r - GREG_START_D);
  assign jyr_len  = (yoff_r == 2'd0) ? 9'd366 : 9'd365;
  assign gyr_leap = jdcd_pkg::cyc_leap(cyc_r);
  assign gyr_len  = gyr_leap ? 9'd366 : 9'd365;
  assign mon_len  = jdcd_pkg::month_len(leap_r, mon_r);
  assign k_years  = {div_quo[jdcd_pkg::JQ_W-1:0], 2'b00} + KW'(yoff_r);

  jdcd_sdiv #(
    .DAY_BITS(DAY_BITS)
  ) u_sdiv (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (div_ctl),
    .dividend (div_dividend),
    .stat     (div_stat),
    .quo      (div_quo),
    .rem      (div_rem)
  );

  always_comb begin
    state_nxt    = state_r;
    num_nxt      = num_r;
    julian_nxt   = julian_r;
    rem_nxt      = rem_r;
    yoff_nxt     = yoff_r;
    cyc_nxt      = cyc_r;
    leap_nxt     = leap_r;
    mon_nxt      = mon_r;
    year_nxt     = year_r;
    bc_nxt       = bc_r;
    dom_nxt      = dom_r;
    month_nxt    = month_r;
    div_ctl      = '0;
    div_dividend = num_r;
    case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          num_nxt   = in_day_number;
          state_nxt = S_PREP;
        end
      end
      S_PREP: begin
        mon_nxt  = 4'd0;
        yoff_nxt = 2'd0;
        if (num_r < GREG_START_D) begin
          julian_nxt    = 1'b1;
          div_ctl.start = 1'b1;
          state_nxt     = S_DIV;
        end else if (num_r < GREG_YEAR0_D) begin
          // Gregorian days left in 1582: 15 October to 31 December.
          year_nxt = YW'(1582);
          bc_nxt   = 1'b0;
          if (e_low < 7'd17) begin
            dom_nxt   = 5'(e_low + 7'd15);
            month_nxt = 4'd10;
          end else if (e_low < 7'd47) begin
            dom_nxt   = 5'(e_low - 7'd16);
            month_nxt = 4'd11;
          end else begin
            dom_nxt   = 5'(e_low - 7'd46);
            month_nxt = 4'd12;
          end
          state_nxt = S_FIN;
        end else begin
          julian_nxt    = 1'b0;
          div_dividend  = num_r - GREG_YEAR0_D;
          div_ctl.start = 1'b1;
          div_ctl.greg  = 1'b1;
          state_nxt     = S_DIV;
        end
      end
      S_DIV: begin
        if (div_stat.done) begin
          rem_nxt   = div_rem;
          state_nxt = julian_r ? S_JYR : S_GADD;
        end
      end
      S_JYR: begin
        // The first year of each Julian four-year group is the leap year.
        if (yoff_r == 2'd3 || rem_r < RW'(jyr_len)) begin
          leap_nxt  = (yoff_r == 2'd0);
          state_nxt = S_JK;
        end else begin
          rem_nxt  = rem_r - RW'(jyr_len);
          yoff_nxt = yoff_r + 2'd1;
        end
      end
      S_JK: begin
        if (k_years <= KW'(4712)) begin
          bc_nxt   = 1'b1;
          year_nxt = YW'(KW'(4713) - k_years);
        end else begin
          bc_nxt   = 1'b0;
          year_nxt = YW'(k_years - KW'(4712));
        end
        state_nxt = S_MON;
      end
      S_GADD: begin
        // Only the low year bits matter, so only the low quotient bits enter.
        year_nxt  = YW'(div_quo[YW-1:0] * YW'(400)) + YW'(1583);
        bc_nxt    = 1'b0;
        cyc_nxt   = CW'(383);
        state_nxt = S_GYR;
      end
      S_GYR: begin
        if (rem_r < RW'(gyr_len)) begin
          leap_nxt  = gyr_leap;
          state_nxt = S_MON;
        end else begin
          rem_nxt  = rem_r - RW'(gyr_len);
          year_nxt = year_r + YW'(1);
          cyc_nxt  = (cyc_r == CW'(399)) ? '0 : cyc_r + CW'(1);
        end
      end
      S_MON: begin
        if (mon_r == 4'd11 || rem_r < RW'(mon_len)) begin
          dom_nxt   = 5'(rem_r) + 5'd1;
          month_nxt = mon_r + 4'd1;
          state_nxt = S_FIN;
        end else begin
          rem_nxt = rem_r - RW'(mon_len);
          mon_nxt = mon_r + 4'd1;
        end
      end
      S_FIN: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Output register: loaded from the finished date, emptied when taken.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (state_r == S_FIN && out_free) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    num_r    <= num_nxt;
    julian_r <= julian_nxt;
    rem_r    <= rem_nxt;
    yoff_r   <= yoff_nxt;
    cyc_r    <= cyc_nxt;
    leap_r   <= leap_nxt;
    mon_r    <= mon_nxt;
    year_r   <= year_nxt;
    bc_r     <= bc_nxt;
    dom_r    <= dom_nxt;
    month_r  <= month_nxt;
    if (state_r == S_FIN && out_free) begin
      out_dom_r  <= dom_r;
      out_mon_r  <= month_r;
      out_year_r <= year_r;
      out_bc_r   <= bc_r;
    end
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_day_of_month  = out_dom_r;
  assign out_month         = out_mon_r;
  assign out_year_number   = out_year_r;
  assign out_before_christ = out_bc_r;

  // The divider is only started when it is free.
  a_div_start_free: assert property (@(posedge clk) disable iff (!rst_n)
    div_ctl.start |-> !div_stat.busy)
    else $error("divider started while busy");

  // A finished division leaves a remainder below the selected cycle length.
  a_div_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV && div_stat.done) |->
      (div_rem < (julian_r ? jdcd_pkg::JUL_CYCLE : jdcd_pkg::GREG_CYCLE)))
    else $error("division remainder out of range");

  // An accepted day number starts the sequencer on the next cycle.
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> state_r == S_PREP)
    else $error("accepted transaction did not start conversion");

  // The month walk never runs past December.
  a_month_walk: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_MON |-> mon_r <= 4'd11)
    else $error("month walk past December");

  // A result leaving the block is a real date.
  a_out_date: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_month != 4'd0 && out_month <= 4'd12 &&
                   out_day_of_month != 5'd0 && out_year_number != '0))
    else $error("result is not a valid date");

endmodule

`default_nettype wire

// File: rtl/core/jdcd_sdiv.sv
// Bit-serial restoring divider by one of two constant cycle lengths (1461 or
// 146097). One quotient bit per cycle. Depends on jdcd_pkg.
`default_nettype none

module jdcd_sdiv #(
  parameter int DAY_BITS = jdcd_pkg::DAY_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire jdcd_pkg::div_ctl_t            ctl,
  input  wire logic [DAY_BITS-1:0]           dividend,
  output jdcd_pkg::div_stat_t                stat,
  output logic [DAY_BITS-1:0]                quo,
  output logic [jdcd_pkg::REM_W-1:0]         rem
);

  localparam int CNT_W = $clog2(DAY_BITS);

  logic [DAY_BITS-1:0]        num_r, num_nxt;
  logic [jdcd_pkg::REM_W-1:0] rem_r, rem_nxt;
  logic [CNT_W-1:0]           cnt_r, cnt_nxt;
  logic                       busy_r, busy_nxt;
  logic                       done_r, done_nxt;
  logic                       greg_r, greg_nxt;
  logic [jdcd_pkg::REM_W-1:0] divisor;
  logic [jdcd_pkg::REM_W:0]   trial;
  logic                       qbit;

  assign divisor = greg_r ? jdcd_pkg::GREG_CYCLE : jdcd_pkg::JUL_CYCLE;
  assign trial   = {rem_r, num_r[DAY_BITS-1]} - {1'b0, divisor};
  assign qbit    = !trial[jdcd_pkg::REM_W];

  always_comb begin
    num_nxt  = num_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    greg_nxt = greg_r;
    done_nxt = 1'b0;
    if (ctl.start) begin
      num_nxt  = dividend;
      rem_nxt  = '0;
      cnt_nxt  = CNT_W'(DAY_BITS - 1);
      busy_nxt = 1'b1;
      greg_nxt = ctl.greg;
    end else if (busy_r) begin
      num_nxt = {num_r[DAY_BITS-2:0], qbit};
      rem_nxt = qbit ? trial[jdcd_pkg::REM_W-1:0]
                     : {rem_r[jdcd_pkg::REM_W-2:0], num_r[DAY_BITS-1]};
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    num_r  <= num_nxt;
    rem_r  <= rem_nxt;
    cnt_r  <= cnt_nxt;
    greg_r <= greg_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign stat = '{busy: busy_r, done: done_r};
  assign quo  = num_r;
  assign rem  = rem_r;

endmodule

`default_nettype wire
